/* sv/bidirectional_flow_counter_table_assert.svh */
// assertion macros for the flow counter table
`ifndef BIDIRECTIONAL_FLOW_COUNTER_TABLE_ASSERT_SVH
`define BIDIRECTIONAL_FLOW_COUNTER_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bfct assertion failed");
`define BFCT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bfct assertion failed");
`else
`define BFCT_ASSERT(lbl, prop)
`define BFCT_ASSERT_RST(lbl, prop)
`endif
`endif

/* sv/bfct_pkg.sv */
`default_nettype none
package bfct_pkg;
  localparam int BUCKETS = 256;
  localparam int WAYS    = 4;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W  = 10;

  localparam logic [1:0] ST_FWD  = 2'd0;
  localparam logic [1:0] ST_REV  = 2'd1;
  localparam logic [1:0] ST_NEW  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [63:0] sh;
    logic [63:0] sl;
    logic [63:0] dh;
    logic [63:0] dl;
    logic [39:0] pp;
  } tuple_t;

  typedef struct packed {
    logic [31:0] fp;
    logic [47:0] fb;
    logic [31:0] rp;
    logic [47:0] rb;
  } cnt_t;

  typedef struct packed {
    logic [WAYS-1:0]   valid;
    tuple_t [WAYS-1:0] tup;
  } tag_row_t;

  typedef cnt_t [WAYS-1:0] cnt_row_t;

  typedef struct packed {
    logic clr;
    logic load_in;
    logic rd;
    logic eval;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

/* sv/bidirectional_flow_counter_table.sv */
// a request is accepted in idle, its bucket read, compared, then written back
// together with the result load, which waits while an untaken result is held;
// one request at a time, the next accepted the cycle after write-back, set by
// the bucket read-modify-write. after reset a clearing pass over every bucket
// wipes the tag memory valid bits; no request is accepted until it ends
`default_nettype none
module bidirectional_flow_counter_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        addr_kind_i,
  input  wire logic [63:0] src_addr_high_i,
  input  wire logic [63:0] src_addr_low_i,
  input  wire logic [63:0] dst_addr_high_i,
  input  wire logic [63:0] dst_addr_low_i,
  input  wire logic [7:0]  protocol_i,
  input  wire logic [15:0] src_port_num_i,
  input  wire logic [15:0] dst_port_num_i,
  input  wire logic [15:0] packet_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [9:0]       slot_index_o,
  output logic [31:0]      fwd_packets_o,
  output logic [47:0]      fwd_bytes_o,
  output logic [31:0]      rev_packets_o,
  output logic [47:0]      rev_bytes_o
);
  // controller sequences clear, read, compare and commit
  bfct_pkg::cmd_t cmd;
  bfct_pkg::sts_t sts;

  bfct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds the request, bucket memories and result register
  bfct_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .addr_kind_i     (addr_kind_i),
    .src_addr_high_i (src_addr_high_i),
    .src_addr_low_i  (src_addr_low_i),
    .dst_addr_high_i (dst_addr_high_i),
    .dst_addr_low_i  (dst_addr_low_i),
    .protocol_i      (protocol_i),
    .src_port_num_i  (src_port_num_i),
    .dst_port_num_i  (dst_port_num_i),
    .packet_length_i (packet_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .fwd_packets_o   (fwd_packets_o),
    .fwd_bytes_o     (fwd_bytes_o),
    .rev_packets_o   (rev_packets_o),
    .rev_bytes_o     (rev_bytes_o)
  );
endmodule
`default_nettype wire

/* sv/bfct_ram.sv */
`default_nettype none
module bfct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/bfct_ctrl.sv */
`default_nettype none
`include "bidirectional_flow_counter_table_assert.svh"
module bfct_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bfct_pkg::sts_t sts_i,
  output bfct_pkg::cmd_t     cmd_o
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        if (sts_i.clr_done) state_d = S_IDLE;
        else cmd_o.clr = 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.eval = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else state_q <= state_d;
  end

  `BFCT_ASSERT(a_accept_reads, (in_valid_i && in_ready_o) |=> (state_q == S_RD))
  `BFCT_ASSERT(a_cmp_after_rd, (state_q == S_CMP) |-> ($past(state_q) == S_RD))
  `BFCT_ASSERT_RST(a_no_accept_clr, !sts_i.clr_done |-> !in_ready_o)
endmodule
`default_nettype wire

/* sv/bfct_dp.sv */
`default_nettype none
module bfct_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bfct_pkg::cmd_t cmd_i,
  output bfct_pkg::sts_t      sts_o,
  input  wire logic           addr_kind_i,
  input  wire logic [63:0]    src_addr_high_i,
  input  wire logic [63:0]    src_addr_low_i,
  input  wire logic [63:0]    dst_addr_high_i,
  input  wire logic [63:0]    dst_addr_low_i,
  input  wire logic [7:0]     protocol_i,
  input  wire logic [15:0]    src_port_num_i,
  input  wire logic [15:0]    dst_port_num_i,
  input  wire logic [15:0]    packet_length_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          status_o,
  output logic [9:0]          slot_index_o,
  output logic [31:0]         fwd_packets_o,
  output logic [47:0]         fwd_bytes_o,
  output logic [31:0]         rev_packets_o,
  output logic [47:0]         rev_bytes_o
);
  localparam int BKT_W = bfct_pkg::BKT_W;
  localparam int WAY_W = bfct_pkg::WAY_W;
  localparam int WAYS  = bfct_pkg::WAYS;

  // captured request, ipv4 upper bits forced to zero
  logic        kind_q;
  logic [63:0] sh_q, sl_q, dh_q, dl_q;
  logic [7:0]  proto_q;
  logic [15:0] sp_q, dp_q, len_q;
  logic [BKT_W-1:0] bucket_q;
  logic [BKT_W:0]   clr_cnt_q;

  logic [63:0] sh_m, sl_m, dh_m, dl_m;
  logic [31:0] hash;

  always_comb begin
    sh_m = addr_kind_i ? src_addr_high_i : 64'd0;
    dh_m = addr_kind_i ? dst_addr_high_i : 64'd0;
    sl_m = addr_kind_i ? src_addr_low_i : {32'd0, src_addr_low_i[31:0]};
    dl_m = addr_kind_i ? dst_addr_low_i : {32'd0, dst_addr_low_i[31:0]};
    hash = sh_m[63:32] ^ sh_m[31:0] ^ sl_m[63:32] ^ sl_m[31:0]
         ^ dh_m[63:32] ^ dh_m[31:0] ^ dl_m[63:32] ^ dl_m[31:0]
         ^ {16'd0, src_port_num_i} ^ {16'd0, dst_port_num_i} ^ {24'd0, protocol_i};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q   <= addr_kind_i;
      sh_q     <= sh_m;
      sl_q     <= sl_m;
      dh_q     <= dh_m;
      dl_q     <= dl_m;
      proto_q  <= protocol_i;
      sp_q     <= src_port_num_i;
      dp_q     <= dst_port_num_i;
      len_q    <= packet_length_i;
      // bucket count is a power of two, so the modulo is a mask
      bucket_q <= BKT_W'(hash % bfct_pkg::BUCKETS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  assign sts_o.clr_done = (clr_cnt_q == (BKT_W+1)'(bfct_pkg::BUCKETS));

  // rams
  bfct_pkg::tag_row_t tag_rd, tag_wr_q;
  bfct_pkg::cnt_row_t cnt_rd, cnt_wr_q;
  logic [1:0]       stat_q;
  logic [WAY_W-1:0] way_q;
  bfct_pkg::cnt_t   cnt_new_q;
  logic [BKT_W-1:0] waddr;

  assign waddr = cmd_i.clr ? clr_cnt_q[BKT_W-1:0] : bucket_q;

  bfct_ram #(.WIDTH($bits(bfct_pkg::tag_row_t)), .DEPTH(bfct_pkg::BUCKETS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr | (cmd_i.commit & (stat_q == bfct_pkg::ST_NEW))),
    .waddr_i (waddr),
    .wdata_i (cmd_i.clr ? '0 : tag_wr_q),
    .re_i    (cmd_i.rd),
    .raddr_i (bucket_q),
    .rdata_o (tag_rd)
  );

  bfct_ram #(.WIDTH($bits(bfct_pkg::cnt_row_t)), .DEPTH(bfct_pkg::BUCKETS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit & (stat_q != bfct_pkg::ST_FULL)),
    .waddr_i (bucket_q),
    .wdata_i (cnt_wr_q),
    .re_i    (cmd_i.rd),
    .raddr_i (bucket_q),
    .rdata_o (cnt_rd)
  );

  // parallel compare over the bucket
  bfct_pkg::tuple_t   fwd_t, rev_t;
  logic               hit, hrev, free;
  logic [WAY_W-1:0]   hway, fway;
  logic [1:0]         stat_d;
  bfct_pkg::cnt_t     cold, cnew;
  logic [WAY_W-1:0]   way_d;
  bfct_pkg::tag_row_t tag_wr_d;
  bfct_pkg::cnt_row_t cnt_wr_d;

  always_comb begin
    fwd_t = '{kind_q, sh_q, sl_q, dh_q, dl_q, {proto_q, sp_q, dp_q}};
    rev_t = '{kind_q, dh_q, dl_q, sh_q, sl_q, {proto_q, dp_q, sp_q}};
    hit  = 1'b0;
    hrev = 1'b0;
    free = 1'b0;
    hway = '0;
    fway = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && tag_rd.valid[w] && (tag_rd.tup[w] == fwd_t || tag_rd.tup[w] == rev_t)) begin
        hit  = 1'b1;
        hway = WAY_W'(w);
        hrev = (tag_rd.tup[w] != fwd_t);
      end
      if (!free && !tag_rd.valid[w]) begin
        free = 1'b1;
        fway = WAY_W'(w);
      end
    end
    way_d = hit ? hway : fway;
    cold  = cnt_rd[way_d];
    cnew  = cold;
    if (hit && !hrev) begin
      stat_d  = bfct_pkg::ST_FWD;
      cnew.fp = cold.fp + 32'd1;
      cnew.fb = cold.fb + {32'd0, len_q};
    end else if (hit) begin
      stat_d  = bfct_pkg::ST_REV;
      cnew.rp = cold.rp + 32'd1;
      cnew.rb = cold.rb + {32'd0, len_q};
    end else if (free) begin
      stat_d = bfct_pkg::ST_NEW;
      cnew   = '{32'd1, {32'd0, len_q}, 32'd0, 48'd0};
    end else begin
      stat_d = bfct_pkg::ST_FULL;
      cnew   = '0;
    end
    // rows to write back
    tag_wr_d = tag_rd;
    tag_wr_d.valid[way_d] = 1'b1;
    tag_wr_d.tup[way_d]   = fwd_t;
    cnt_wr_d = cnt_rd;
    cnt_wr_d[way_d] = cnew;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      stat_q    <= stat_d;
      way_q     <= way_d;
      cnt_new_q <= cnew;
      tag_wr_q  <= tag_wr_d;
      cnt_wr_q  <= cnt_wr_d;
    end
  end

  // result register
  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.commit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o      <= stat_q;
      slot_index_o  <= (stat_q == bfct_pkg::ST_FULL) ? '0 :
                       bfct_pkg::SLOT_W'(int'(bucket_q) * WAYS + int'(way_q));
      fwd_packets_o <= cnt_new_q.fp;
      fwd_bytes_o   <= cnt_new_q.fb;
      rev_packets_o <= cnt_new_q.rp;
      rev_bytes_o   <= cnt_new_q.rb;
    end
  end
endmodule
`default_nettype wire
